FILE: sv/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

FILE: sv/tked_pkg.sv
// types, constants and helper functions for the terminal key decoder
`default_nettype none

package tked_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int OUT_COORD_W = 16;

    localparam logic [7:0] KEY_NUL     = 8'd0;
    localparam logic [7:0] KEY_ESC     = 8'd27;
    localparam logic [7:0] KEY_BRACKET = 8'd91;
    localparam logic [7:0] UPPER_LO    = 8'd64;   // exclusive bounds of A..Z
    localparam logic [7:0] UPPER_HI    = 8'd91;
    localparam logic [7:0] LOWER_LO    = 8'd96;   // exclusive bounds of a..z
    localparam logic [7:0] LOWER_HI    = 8'd123;
    localparam logic [7:0] KEY_CAP_A   = 8'd65;
    localparam logic [7:0] KEY_CAP_B   = 8'd66;
    localparam logic [7:0] KEY_CAP_C   = 8'd67;
    localparam logic [7:0] KEY_CAP_D   = 8'd68;

    typedef enum logic [2:0] {
        EV_LEFT  = 3'd0,
        EV_DOWN  = 3'd1,
        EV_UP    = 3'd2,
        EV_RIGHT = 3'd3,
        EV_QUIT  = 3'd4
    } event_t;

    typedef logic [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        logic       escape_active;
        logic [1:0] seq_count;
        logic [7:0] seq_b0;
        logic [7:0] seq_b1;
        coord_t     pos_x;
        coord_t     pos_y;
        logic       stopped;
    } state_t;

    typedef struct packed {
        logic   valid;
        event_t code;
    } result_t;

    function automatic logic is_letter(input logic [7:0] b);
        return ((b > UPPER_LO) && (b < UPPER_HI)) || ((b > LOWER_LO) && (b < LOWER_HI));
    endfunction

    // plain-mode key map, both cases
    function automatic result_t plain_lookup(input logic [7:0] b);
        result_t r;
        r.valid = 1'b1;
        r.code  = EV_LEFT;
        unique case (b)
            "h", "H", "a", "A": r.code = EV_LEFT;
            "j", "J", "s", "S": r.code = EV_DOWN;
            "k", "K", "w", "W": r.code = EV_UP;
            "l", "L", "d", "D": r.code = EV_RIGHT;
            "q", "Q":           r.code = EV_QUIT;
            default:            r.valid = 1'b0;
        endcase
        return r;
    endfunction

    // sign-extend a coordinate and cut it to the output width
    function automatic logic [OUT_COORD_W-1:0] coord_out(input coord_t c);
        logic [31:0] ext;
        ext = 32'(signed'(c));
        return ext[OUT_COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/tked_core.sv
// next-state and event logic for one terminal byte
`default_nettype none

module tked_core (
    input  wire logic [7:0]       key_byte,
    input  wire logic             frame_start,
    input  wire tked_pkg::state_t cur,
    output tked_pkg::state_t      nxt,
    output tked_pkg::result_t     res
);

    tked_pkg::result_t plain_res;
    logic              esc_after_fs;

    assign plain_res    = tked_pkg::plain_lookup(key_byte);
    assign esc_after_fs = cur.escape_active & ~frame_start;

    always_comb begin
        nxt       = cur;
        res.valid = 1'b0;
        res.code  = tked_pkg::EV_LEFT;

        if (!cur.stopped) begin
            nxt.escape_active = esc_after_fs;
            if (key_byte == tked_pkg::KEY_NUL) begin
                // nothing beyond the frame-start clear
            end else if (key_byte == tked_pkg::KEY_ESC) begin
                nxt.escape_active = 1'b1;
                nxt.seq_count     = 2'd0;
                nxt.seq_b0        = 8'd0;
                nxt.seq_b1        = 8'd0;
            end else if (!esc_after_fs) begin
                res = plain_res;
            end else begin
                // keep the first two bytes of the sequence
                if (cur.seq_count == 2'd0) begin
                    nxt.seq_b0    = key_byte;
                    nxt.seq_count = 2'd1;
                end else if (cur.seq_count == 2'd1) begin
                    nxt.seq_b1    = key_byte;
                    nxt.seq_count = 2'd2;
                end
                if (tked_pkg::is_letter(key_byte)) begin
                    nxt.escape_active = 1'b0;
                    if (nxt.seq_b0 == tked_pkg::KEY_BRACKET) begin
                        res.valid = 1'b1;
                        unique case (nxt.seq_b1)
                            tked_pkg::KEY_CAP_A: res.code = tked_pkg::EV_UP;
                            tked_pkg::KEY_CAP_B: res.code = tked_pkg::EV_DOWN;
                            tked_pkg::KEY_CAP_C: res.code = tked_pkg::EV_RIGHT;
                            tked_pkg::KEY_CAP_D: res.code = tked_pkg::EV_LEFT;
                            default:             res.valid = 1'b0;
                        endcase
                    end
                end
            end

            if (res.valid) begin
                unique case (res.code)
                    tked_pkg::EV_LEFT:  nxt.pos_x   = cur.pos_x - 1'b1;
                    tked_pkg::EV_RIGHT: nxt.pos_x   = cur.pos_x + 1'b1;
                    tked_pkg::EV_UP:    nxt.pos_y   = cur.pos_y - 1'b1;
                    tked_pkg::EV_DOWN:  nxt.pos_y   = cur.pos_y + 1'b1;
                    tked_pkg::EV_QUIT:  nxt.stopped = 1'b1;
                    default:            nxt.stopped = cur.stopped;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/terminal_key_escape_decoder.sv
// top level of the terminal key decoder: input register, decode, result register
//
// usage
//   s_ channel: one raw terminal byte per beat in s_tdata, s_tuser high marks the
//   first byte of a new polling frame and drops any escape sequence in progress
//   m_ channel: one beat per movement or quit event, carrying the event code and
//   the cursor coordinates after the event; bytes that cause no event give no beat
//   an accepted byte goes from the input register through decode into the result
//   register, which drives its event on m_; throughput: one byte per cycle unless
//   m_ stalls, set by the single decode stage between the two registers
//   stall: while m_tvalid is high and m_tready low, the pending byte stays in the
//   input register and s_tready drops; s_tready follows m_tready combinationally
//   reset: aresetn low at a clock edge clears both registers, the cursor (0,0),
//   escape mode and the quit flag
//   after a quit event every further byte is taken and dropped
`default_nettype none
`include "assert_macros.svh"

module terminal_key_escape_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] key_byte
    input  wire logic        s_tuser,   // [0] frame_start
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // [2:0] event_code, [18:3] cursor_x,
                                        // [34:19] cursor_y, [39:35] zero
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_fs_reg;

    // decoder state
    tked_pkg::state_t st_reg, st_next;

    // result register
    logic                 out_valid_reg, out_valid_next;
    tked_pkg::event_t     out_code_reg;
    logic [15:0]          out_x_reg;
    logic [15:0]          out_y_reg;

    tked_pkg::result_t res;
    logic              s_accept;
    logic              out_free;
    logic              advance;

    // result slot can take a new value when empty or being drained this cycle
    assign out_free = ~out_valid_reg | m_tready;
    assign advance  = in_valid_reg & out_free;
    assign s_tready = ~in_valid_reg | out_free;
    assign s_accept = s_tvalid & s_tready;

    tked_core u_core (
        .key_byte    (in_byte_reg),
        .frame_start (in_fs_reg),
        .cur         (st_reg),
        .nxt         (st_next),
        .res         (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = advance & res.valid;
        end
    end

    // control and decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                st_reg <= st_next;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_fs_reg   <= s_tuser;
        end
        if (advance && res.valid) begin
            out_code_reg <= res.code;
            out_x_reg    <= tked_pkg::coord_out(st_next.pos_x);
            out_y_reg    <= tked_pkg::coord_out(st_next.pos_y);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_y_reg, out_x_reg, out_code_reg};

    // quit is final
    `ASSERT_NEXT(a_stopped_sticky, aclk, aresetn, st_reg.stopped, st_reg.stopped)
    // once stopped, an empty result slot stays empty
    `ASSERT_NEXT(a_no_beat_after_quit, aclk, aresetn,
        st_reg.stopped && !out_valid_reg, !out_valid_reg)
    // a byte held behind a stalled result is not lost
    `ASSERT_NEXT(a_hold_on_stall, aclk, aresetn,
        in_valid_reg && out_valid_reg && !m_tready, in_valid_reg)
    // only defined event codes leave the block
    `ASSERT_SAME(a_code_range, aclk, aresetn, out_valid_reg,
        out_code_reg == tked_pkg::EV_LEFT || out_code_reg == tked_pkg::EV_DOWN ||
        out_code_reg == tked_pkg::EV_UP || out_code_reg == tked_pkg::EV_RIGHT ||
        out_code_reg == tked_pkg::EV_QUIT)

endmodule

`default_nettype wire

FILE: sim/terminal_key_escape_decoder_tb.sv
// testbench for the terminal key decoder: directed and random byte streams checked by a cursor model
`default_nettype none

module terminal_key_escape_decoder_tb;

    localparam int STALL_LIMIT = 2000;     // cycles with no beat on either side
    localparam int RANDOM_ITEMS = 800;
    localparam int DRAIN_CYCLES = 8;
    localparam int WRAP_STEPS = 40;        // origin past zero into negative values

    // keys that move the cursor in plain mode, both cases
    localparam logic [7:0] MOVE_KEYS [16] = '{"h", "H", "a", "A", "j", "J", "s", "S",
                                              "k", "K", "w", "W", "l", "L", "d", "D"};

    typedef struct packed {
        tked_pkg::event_t code;
        logic [15:0]      x;
        logic [15:0]      y;
    } cursor_event_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    // mirror of the decoder state
    logic             halted = 1'b0;
    logic             esc_on = 1'b0;
    logic [1:0]       seq_len = 2'd0;
    logic [7:0]       seq_first = 8'd0;
    logic [7:0]       seq_second = 8'd0;
    tked_pkg::coord_t cur_x = '0;
    tked_pkg::coord_t cur_y = '0;

    cursor_event_t pending_moves[$];
    int          failures = 0;
    int          mismatches = 0;
    int          stall_cycles = 0;
    logic        calm = 1'b0;          // no idling on either side while set
    logic        quit_allowed = 1'b0;  // quit only at the very end, reset is never repeated

    terminal_key_escape_decoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // next cursor event for one accepted byte, if any
    task automatic decode_key(input logic [7:0] b, input logic fs);
        logic             has_ev;
        tked_pkg::event_t ev;
        has_ev = 1'b0;
        ev = tked_pkg::EV_LEFT;
        if (halted)
            return;
        if (fs)
            esc_on = 1'b0;
        if (b == tked_pkg::KEY_NUL)
            return;
        if (b == tked_pkg::KEY_ESC) begin
            seq_len = 2'd0;
            seq_first = 8'd0;
            seq_second = 8'd0;
            esc_on = 1'b1;
            return;
        end
        if (!esc_on) begin
            has_ev = 1'b1;
            case (b)
                "h", "H", "a", "A": ev = tked_pkg::EV_LEFT;
                "j", "J", "s", "S": ev = tked_pkg::EV_DOWN;
                "k", "K", "w", "W": ev = tked_pkg::EV_UP;
                "l", "L", "d", "D": ev = tked_pkg::EV_RIGHT;
                "q", "Q":           ev = tked_pkg::EV_QUIT;
                default:            has_ev = 1'b0;
            endcase
        end else begin
            // only the first two bytes after escape are kept
            if (seq_len == 2'd0)
                seq_first = b;
            else if (seq_len == 2'd1)
                seq_second = b;
            if (seq_len < 2'd2)
                seq_len = seq_len + 2'd1;
            if ((b > tked_pkg::UPPER_LO && b < tked_pkg::UPPER_HI) ||
                (b > tked_pkg::LOWER_LO && b < tked_pkg::LOWER_HI)) begin
                esc_on = 1'b0;
                if (seq_first == tked_pkg::KEY_BRACKET) begin
                    has_ev = 1'b1;
                    case (seq_second)
                        tked_pkg::KEY_CAP_A: ev = tked_pkg::EV_UP;
                        tked_pkg::KEY_CAP_B: ev = tked_pkg::EV_DOWN;
                        tked_pkg::KEY_CAP_C: ev = tked_pkg::EV_RIGHT;
                        tked_pkg::KEY_CAP_D: ev = tked_pkg::EV_LEFT;
                        default:             has_ev = 1'b0;
                    endcase
                end
            end
        end
        if (!has_ev)
            return;
        case (ev)
            tked_pkg::EV_LEFT:  cur_x = cur_x - 1'b1;
            tked_pkg::EV_DOWN:  cur_y = cur_y + 1'b1;
            tked_pkg::EV_UP:    cur_y = cur_y - 1'b1;
            tked_pkg::EV_RIGHT: cur_x = cur_x + 1'b1;
            default:            halted = 1'b1;
        endcase
        pending_moves.push_back('{ev, tked_pkg::OUT_COORD_W'(signed'(cur_x)),
                                  tked_pkg::OUT_COORD_W'(signed'(cur_y))});
    endtask

    // result check first, then the byte taken at the same edge
    always @(posedge aclk) begin
        cursor_event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_moves.size() == 0) begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: code %0d x %0d y %0d", m_tdata[2:0],
                             $signed(m_tdata[18:3]), $signed(m_tdata[34:19]));
            end else begin
                want = pending_moves.pop_front();
                if (m_tdata[2:0] !== want.code || m_tdata[18:3] !== want.x ||
                    m_tdata[34:19] !== want.y || m_tdata[39:35] !== 5'd0) begin
                    failures++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected code %0d x %0d y %0d, ",
                                  "got code %0d x %0d y %0d pad %h"},
                                 want.code, $signed(want.x), $signed(want.y), m_tdata[2:0],
                                 $signed(m_tdata[18:3]), $signed(m_tdata[34:19]),
                                 m_tdata[39:35]);
                end
            end
        end
        if (aresetn && s_tvalid && s_tready)
            decode_key(s_tdata, s_tuser);
    end

    // result side stalls at random
    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 12);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // one byte beat, with random gaps ahead of it
    task automatic send_key(input logic [7:0] key, input logic fs);
        @(negedge aclk);
        while (!calm && $urandom_range(0, 99) < 12) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        // a quit in plain mode would end the run early
        if (!quit_allowed && (key == "q" || key == "Q") && (fs || !esc_on))
            key = key + 8'd1;
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= fs;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic rare_frame();
        return $urandom_range(0, 99) < 3;
    endfunction

    function automatic logic [7:0] any_letter();
        return ($urandom_range(0, 1) ? 8'd65 : 8'd97) + 8'($urandom_range(0, 25));
    endfunction

    // each direction twice (hjkl and asdw sets), plus bytes that do nothing; cursor ends at the origin
    task automatic test_plain_keys();
        send_key("h", 1'b0);
        send_key("J", 1'b0);
        send_key("k", 1'b0);
        send_key("L", 1'b0);
        send_key("A", 1'b0);
        send_key("s", 1'b0);
        send_key("W", 1'b0);
        send_key("d", 1'b0);
        send_key(tked_pkg::KEY_NUL, 1'b1);
        send_key(8'hFF, 1'b0);
        send_key(8'h80, 1'b1);
    endtask

    // arrow sequence, frame start inside a sequence, escape in escape mode, short sequence
    task automatic test_escape_sequences();
        send_key(tked_pkg::KEY_ESC, 1'b0);
        send_key(tked_pkg::KEY_BRACKET, 1'b0);
        send_key(tked_pkg::KEY_CAP_A, 1'b0);
        send_key(tked_pkg::KEY_ESC, 1'b0);
        send_key(tked_pkg::KEY_BRACKET, 1'b0);
        send_key(tked_pkg::KEY_CAP_C, 1'b1);      // taken as a plain byte
        send_key(tked_pkg::KEY_ESC, 1'b0);
        send_key(tked_pkg::KEY_ESC, 1'b0);
        send_key(tked_pkg::KEY_BRACKET, 1'b0);
        send_key(tked_pkg::KEY_CAP_B, 1'b0);
        send_key(tked_pkg::KEY_ESC, 1'b0);
        send_key(tked_pkg::KEY_CAP_A, 1'b0);      // sequence too short to match
    endtask

    // walk both coordinates below zero so they wrap, then one step back
    task automatic test_cursor_wrap();
        calm = 1'b1;
        repeat (WRAP_STEPS) send_key("a", 1'b0);
        repeat (WRAP_STEPS) send_key("w", 1'b0);
        send_key("d", 1'b0);
        send_key("s", 1'b0);
        calm = 1'b0;
    endtask

    // arrow sequences with random direction, plain move keys, noise and broken sequences, mixed at random
    task automatic test_random_traffic();
        int sent;
        int kind;
        int n;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            calm = (sent >= 300 && sent < 450);
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                send_key(tked_pkg::KEY_ESC, rare_frame());
                send_key(tked_pkg::KEY_BRACKET, rare_frame());
                send_key(tked_pkg::KEY_CAP_A + 8'($urandom_range(0, 3)), rare_frame());
                sent += 3;
            end else if (kind < 65) begin
                send_key(MOVE_KEYS[$urandom_range(0, 15)], rare_frame());
                sent += 1;
            end else if (kind < 75) begin
                // long or odd sequences: bytes past the second are dropped
                n = $urandom_range(0, 4);
                send_key(tked_pkg::KEY_ESC, 1'b0);
                repeat (n) send_key(8'($urandom_range(32, 127)), 1'b0);
                send_key(any_letter(), 1'b0);
                sent += n + 2;
            end else if (kind < 90) begin
                send_key(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                sent += 1;
            end else begin
                // frame start drops the sequence, the letter is read as plain
                send_key(tked_pkg::KEY_ESC, 1'b0);
                send_key(tked_pkg::KEY_BRACKET, 1'b0);
                send_key(tked_pkg::KEY_CAP_A + 8'($urandom_range(0, 3)), 1'b1);
                sent += 3;
            end
        end
        calm = 1'b0;
    endtask

    // quit carries the cursor, then everything is ignored
    task automatic test_quit();
        quit_allowed = 1'b1;
        send_key("q", 1'b0);
        send_key("h", 1'b0);
        send_key(tked_pkg::KEY_ESC, 1'b0);
        send_key("Q", 1'b1);
        send_key(tked_pkg::KEY_NUL, 1'b0);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_plain_keys();
        test_escape_sequences();
        test_cursor_wrap();
        test_random_traffic();
        test_quit();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_moves.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
